>>> sv/ssi_pkg.sv
// shared constants, types and width helpers for the segment/sphere test
package ssi_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int RADIUS_BITS    = 20;
  localparam int MARGIN_BITS    = 16;
  localparam int RC_BITS        = RADIUS_BITS + 1;
  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 16'd160;

  typedef enum logic [1:0] {
    DEC_ONE_IN  = 2'd0,
    DEC_BOTH_IN = 2'd1,
    DEC_NO_ROOT = 2'd2,
    DEC_ROOT    = 2'd3
  } decide_t;

  typedef struct packed {
    logic s_in;
    logic e_in;
    logic a_zero;
    logic root_ok;
  } flags_t;

  // width of a dot product sum of three differences
  function automatic int sum_width(input int cb);
    return 2 * (cb + 1) + 1;
  endfunction

  // working width for compares and the quadratic terms
  function automatic int ext_width(input int cb);
    int sw;
    sw = sum_width(cb);
    return ((sw > 2 * RC_BITS) ? sw : 2 * RC_BITS) + 2;
  endfunction

endpackage

>>> sv/ssi_prep.sv
// stages 1-4: differences, products, dot sums, inside tests and root range flags
module ssi_prep import ssi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [MARGIN_BITS-1:0]         check_margin,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [COORD_BITS-1:0]   start_x,
  input  logic signed [COORD_BITS-1:0]   start_y,
  input  logic signed [COORD_BITS-1:0]   start_z,
  input  logic signed [COORD_BITS-1:0]   end_x,
  input  logic signed [COORD_BITS-1:0]   end_y,
  input  logic signed [COORD_BITS-1:0]   end_z,
  input  logic signed [COORD_BITS-1:0]   center_x,
  input  logic signed [COORD_BITS-1:0]   center_y,
  input  logic signed [COORD_BITS-1:0]   center_z,
  input  logic [RADIUS_BITS-1:0]         sphere_radius,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [ext_width(COORD_BITS)-1:0] h_out,
  output logic signed [ext_width(COORD_BITS)-1:0] a_out,
  output logic signed [ext_width(COORD_BITS)-1:0] cc_out,
  output flags_t                         flags_out
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int SW = sum_width(COORD_BITS);
  localparam int XW = ext_width(COORD_BITS);
  localparam int RRW = 2 * RADIUS_BITS;
  localparam int CKW = 2 * RC_BITS;

  logic signed [COORD_BITS-1:0] s [3];
  logic signed [COORD_BITS-1:0] e [3];
  logic signed [COORD_BITS-1:0] c [3];

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [DW-1:0] so1 [3];
  logic signed [DW-1:0] eo1 [3];
  logic signed [DW-1:0] d1  [3];
  logic [RADIUS_BITS-1:0] r1;
  logic [RC_BITS-1:0]     rc1;

  logic signed [PW-1:0] psd2 [3];
  logic signed [PW-1:0] ped2 [3];
  logic signed [PW-1:0] pa2  [3];
  logic signed [PW-1:0] ph2  [3];
  logic [RRW-1:0] rr2;
  logic [CKW-1:0] chk2;

  logic signed [SW-1:0] sd3, ed3, a3, h3;
  logic [RRW-1:0] rr3;
  logic [CKW-1:0] chk3;

  logic signed [XW-1:0] sd_x, ed_x, a_x, h_x, rr_x, chk_x, ah_x;

  assign s[0] = start_x;  assign s[1] = start_y;  assign s[2] = start_z;
  assign e[0] = end_x;    assign e[1] = end_y;    assign e[2] = end_z;
  assign c[0] = center_x; assign c[1] = center_y; assign c[2] = center_z;

  assign rdy4 = !v4 || out_ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // stage 1: offsets from the center and the segment direction
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      for (int i = 0; i < 3; i++) begin
        so1[i] <= DW'(s[i]) - DW'(c[i]);
        eo1[i] <= DW'(e[i]) - DW'(c[i]);
        d1[i]  <= DW'(e[i]) - DW'(s[i]);
      end
      r1  <= sphere_radius;
      rc1 <= RC_BITS'(sphere_radius) + RC_BITS'(check_margin);
    end
  end

  // stage 2: one product per term
  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      for (int i = 0; i < 3; i++) begin
        psd2[i] <= so1[i] * so1[i];
        ped2[i] <= eo1[i] * eo1[i];
        pa2[i]  <= d1[i] * d1[i];
        ph2[i]  <= so1[i] * d1[i];
      end
      rr2  <= RRW'(r1) * RRW'(r1);
      chk2 <= CKW'(rc1) * CKW'(rc1);
    end
  end

  // stage 3: dot sums
  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      sd3  <= SW'(psd2[0]) + SW'(psd2[1]) + SW'(psd2[2]);
      ed3  <= SW'(ped2[0]) + SW'(ped2[1]) + SW'(ped2[2]);
      a3   <= SW'(pa2[0]) + SW'(pa2[1]) + SW'(pa2[2]);
      h3   <= SW'(ph2[0]) + SW'(ph2[1]) + SW'(ph2[2]);
      rr3  <= rr2;
      chk3 <= chk2;
    end
  end

  always_comb begin
    sd_x  = XW'(sd3);
    ed_x  = XW'(ed3);
    a_x   = XW'(a3);
    h_x   = XW'(h3);
    rr_x  = $signed(XW'(rr3));
    chk_x = $signed(XW'(chk3));
    ah_x  = a_x + h_x;
  end

  // stage 4: inside tests, c term and vertex range 0 <= -h <= a
  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      h_out             <= h_x;
      a_out             <= a_x;
      cc_out            <= sd_x - rr_x;
      flags_out.s_in    <= (sd_x <= chk_x);
      flags_out.e_in    <= (ed_x <= chk_x);
      flags_out.a_zero  <= (a3 == '0);
      flags_out.root_ok <= (h_x <= 0) && (ah_x >= 0);
    end
  end

  assign out_valid = v4;

endmodule

>>> sv/ssi_disc.sv
// stages 5-7: split products h*h and a*c, discriminant sign and final decision
module ssi_disc import ssi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [ext_width(COORD_BITS)-1:0] h_in,
  input  logic signed [ext_width(COORD_BITS)-1:0] a_in,
  input  logic signed [ext_width(COORD_BITS)-1:0] cc_in,
  input  flags_t                                  flags_in,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    intersects,
  output logic [1:0]                              decided_by
);

  localparam int XW  = ext_width(COORD_BITS);
  localparam int HW  = XW / 2;
  localparam int UW  = XW - HW;
  localparam int FW  = 2 * XW;

  logic v5, v6, v7;
  logic rdy5, rdy6, rdy7;

  logic [HW-1:0]        h_l, a_l, c_l;
  logic signed [UW-1:0] h_h, a_h, c_h;

  logic [2*HW-1:0]        hll5, all5;
  logic signed [XW:0]     hlh5, alh5, ahl5;
  logic signed [2*UW-1:0] hhh5, ahh5;
  flags_t                 f5, f6;

  logic signed [FW-1:0] h2_6, ac_6;
  logic                 neg_disc;

  assign h_l = h_in[HW-1:0];
  assign a_l = a_in[HW-1:0];
  assign c_l = cc_in[HW-1:0];
  assign h_h = h_in[XW-1:HW];
  assign a_h = a_in[XW-1:HW];
  assign c_h = cc_in[XW-1:HW];

  assign rdy7 = !v7 || out_ready;
  assign rdy6 = !v6 || rdy7;
  assign rdy5 = !v5 || rdy6;
  assign in_ready = rdy5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (rdy5) v5 <= in_valid;
      if (rdy6) v6 <= v5;
      if (rdy7) v7 <= v6;
    end
  end

  // stage 5: partial products on half-width pieces
  always_ff @(posedge clk) begin
    if (rdy5 && in_valid) begin
      hll5 <= (2*HW)'(h_l) * (2*HW)'(h_l);
      hlh5 <= $signed({1'b0, h_l}) * h_h;
      hhh5 <= h_h * h_h;
      all5 <= (2*HW)'(a_l) * (2*HW)'(c_l);
      alh5 <= $signed({1'b0, a_l}) * c_h;
      ahl5 <= $signed({1'b0, c_l}) * a_h;
      ahh5 <= a_h * c_h;
      f5   <= flags_in;
    end
  end

  // stage 6: recombine into full products
  always_ff @(posedge clk) begin
    if (rdy6 && v5) begin
      h2_6 <= (FW'(hhh5) <<< (2*HW)) + (FW'(hlh5) <<< (HW + 1)) + FW'(hll5);
      ac_6 <= (FW'(ahh5) <<< (2*HW)) + ((FW'(alh5) + FW'(ahl5)) <<< HW) + FW'(all5);
      f6   <= f5;
    end
  end

  // discriminant h^2 - a*c below zero
  assign neg_disc = (h2_6 < ac_6);

  // stage 7: decision and output register
  always_ff @(posedge clk) begin
    if (rdy7 && v6) begin
      if (f6.s_in != f6.e_in) begin
        intersects <= 1'b1;
        decided_by <= DEC_ONE_IN;
      end else if (f6.s_in) begin
        intersects <= 1'b0;
        decided_by <= DEC_BOTH_IN;
      end else if (f6.a_zero || neg_disc) begin
        intersects <= 1'b0;
        decided_by <= DEC_NO_ROOT;
      end else begin
        intersects <= f6.root_ok;
        decided_by <= DEC_ROOT;
      end
    end
  end

  assign out_valid = v7;

endmodule

>>> sv/segment_sphere_intersect_unit.sv
// top level of the segment/sphere crossing test
//
// input channel: in_valid/in_stall with the segment end points, sphere center
// (signed Q20.4) and radius (unsigned Q16.4); one transfer per query.
// output channel: out_valid/out_stall with intersects and decided_by
// (0 one end inside, 1 both inside, 2 no real root or zero length, 3 root test).
// margin register: cfg_wr_en/cfg_wr_data write check_margin (Q.4), reset 160.
// an input transfer passes four stages for differences, products, dot sums and
// compares, then three for the split 53-bit products h*h and a*c and the final
// decision, before the result is valid.
// throughput is one query per cycle while out_stall is low; each stage holds its
// own valid bit, so bubbles close up and in_stall rises only when every stage is full.
// when the receiver stalls the result register holds its value and the
// pipeline fills behind it; no query is dropped or repeated.
// synchronous reset empties the pipeline and restores the margin to 10.0.
module segment_sphere_intersect_unit import ssi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [MARGIN_BITS-1:0]       cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] start_z,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic signed [COORD_BITS-1:0] end_z,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic signed [COORD_BITS-1:0] center_z,
  input  logic [RADIUS_BITS-1:0]       sphere_radius,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         intersects,
  output logic [1:0]                   decided_by
);

  localparam int XW = ext_width(COORD_BITS);

  logic [MARGIN_BITS-1:0] check_margin;
  logic                   in_ready;
  logic                   mid_valid, mid_ready;
  logic signed [XW-1:0]   mid_h, mid_a, mid_cc;
  flags_t                 mid_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_margin <= MARGIN_RESET;
    end else if (cfg_wr_en) begin
      check_margin <= cfg_wr_data;
    end
  end

  assign in_stall = !in_ready;

  ssi_prep #(.COORD_BITS(COORD_BITS)) u_prep (
    .clk          (clk),
    .rst          (rst),
    .check_margin (check_margin),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .start_x      (start_x),
    .start_y      (start_y),
    .start_z      (start_z),
    .end_x        (end_x),
    .end_y        (end_y),
    .end_z        (end_z),
    .center_x     (center_x),
    .center_y     (center_y),
    .center_z     (center_z),
    .sphere_radius(sphere_radius),
    .out_valid    (mid_valid),
    .out_ready    (mid_ready),
    .h_out        (mid_h),
    .a_out        (mid_a),
    .cc_out       (mid_cc),
    .flags_out    (mid_flags)
  );

  ssi_disc #(.COORD_BITS(COORD_BITS)) u_disc (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .h_in      (mid_h),
    .a_in      (mid_a),
    .cc_in     (mid_cc),
    .flags_in  (mid_flags),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .intersects(intersects),
    .decided_by(decided_by)
  );

endmodule

>>> sv/ssi_checker.sv
// port-level checks for the segment/sphere unit and the bind that attaches them
module ssi_checker import ssi_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       intersects,
  input logic [1:0] decided_by
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(intersects) && $stable(decided_by))
    else $error("result changed while stalled");

  // a crossing is only reported by the one-end or root rule
  assert property (@(posedge clk) disable iff (rst)
    out_valid && intersects |-> decided_by == DEC_ONE_IN || decided_by == DEC_ROOT)
    else $error("crossing reported by a rejecting rule");

  // one end inside always means a crossing
  assert property (@(posedge clk) disable iff (rst)
    out_valid && decided_by == DEC_ONE_IN |-> intersects)
    else $error("one end inside without crossing");

  // nothing comes out in the cycle after reset
  assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind segment_sphere_intersect_unit ssi_checker u_ssi_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .intersects(intersects),
  .decided_by(decided_by)
);

>>> tb/tb_segment_sphere_intersect_unit.sv
// testbench for the segment/sphere crossing unit: random and directed queries checked against a predictor
module tb_segment_sphere_intersect_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ssi_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int IDLE_PCT = 17;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic signed [CB-1:0] sx, sy, sz, ex, ey, ez, cx, cy, cz;
    logic [RADIUS_BITS-1:0] rad;
  } query_t;

  typedef struct {
    logic hit;
    decide_t path;
  } verdict_t;

  class crossing_scoreboard;
    verdict_t pending[$];
    logic [MARGIN_BITS-1:0] margin;
    int errors;

    function new();
      margin = MARGIN_RESET;
      errors = 0;
    endfunction

    function verdict_t judge(query_t q);
      logic signed [191:0] so[3], eo[3], d[3];
      logic signed [191:0] sd, ed, chk, a, h, cc, disc, nh, rc, r;
      logic s_in, e_in;
      verdict_t v;
      so[0] = 192'(q.sx) - 192'(q.cx); so[1] = 192'(q.sy) - 192'(q.cy);
      so[2] = 192'(q.sz) - 192'(q.cz);
      eo[0] = 192'(q.ex) - 192'(q.cx); eo[1] = 192'(q.ey) - 192'(q.cy);
      eo[2] = 192'(q.ez) - 192'(q.cz);
      d[0] = 192'(q.ex) - 192'(q.sx); d[1] = 192'(q.ey) - 192'(q.sy);
      d[2] = 192'(q.ez) - 192'(q.sz);
      r = {172'd0, q.rad};
      rc = r + {176'd0, margin};
      sd = so[0]*so[0] + so[1]*so[1] + so[2]*so[2];
      ed = eo[0]*eo[0] + eo[1]*eo[1] + eo[2]*eo[2];
      chk = rc * rc;
      s_in = sd <= chk;
      e_in = ed <= chk;
      if (s_in != e_in) begin
        v.hit = 1'b1; v.path = DEC_ONE_IN; return v;
      end
      if (s_in) begin
        v.hit = 1'b0; v.path = DEC_BOTH_IN; return v;
      end
      a = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
      v.hit = 1'b0; v.path = DEC_NO_ROOT;
      if (a == 0) return v;
      h = so[0]*d[0] + so[1]*d[1] + so[2]*d[2];
      cc = sd - r * r;
      disc = h * h - a * cc;
      if (disc < 0) return v;
      nh = -h;
      v.hit = (nh >= 0) && (nh <= a);
      v.path = DEC_ROOT;
      return v;
    endfunction

    function void note_query(query_t q);
      pending.push_back(judge(q));
    endfunction

    function void check_result(logic hit, logic [1:0] path);
      verdict_t v;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result hit=%0d path=%0d", hit, path);
        return;
      end
      v = pending.pop_front();
      if (hit !== v.hit || path !== v.path) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected hit=%0d path=%0d, got hit=%0d path=%0d",
                   v.hit, v.path, hit, path);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_wr_en = 0;
  logic [MARGIN_BITS-1:0] cfg_wr_data = '0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0, intersects;
  logic [1:0] decided_by;
  logic signed [CB-1:0] start_x = 0, start_y = 0, start_z = 0, end_x = 0, end_y = 0;
  logic signed [CB-1:0] end_z = 0, center_x = 0, center_y = 0, center_z = 0;
  logic [RADIUS_BITS-1:0] sphere_radius = 0;

  crossing_scoreboard sb = new();
  bit calm = 0;
  int idle_cycles = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  segment_sphere_intersect_unit u_top (.*);

  // result side: sample on rising edge, stall changes on falling edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(intersects, decided_by);
    if (!rst && ((in_valid && !in_stall) || (out_valid && !out_stall))) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

  // valid stays high after a transfer so the next query can follow directly
  task automatic send(query_t q);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    {start_x, start_y, start_z} <= {q.sx, q.sy, q.sz};
    {end_x, end_y, end_z} <= {q.ex, q.ey, q.ez};
    {center_x, center_y, center_z} <= {q.cx, q.cy, q.cz};
    sphere_radius <= q.rad;
    do @(posedge clk); while (in_stall);
    sb.note_query(q);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_margin(logic [MARGIN_BITS-1:0] m);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en <= 0;
    sb.margin = m;
  endtask

  function automatic logic signed [CB-1:0] pick_coord(int span);
    if ($urandom_range(9) == 0) return CB'($urandom);
    return CB'($signed($urandom_range(2 * span)) - span);
  endfunction

  // mostly queries near the sphere so every decision path is reached
  function automatic query_t random_query();
    query_t q;
    int span;
    span = (1 << $urandom_range(14, 4));
    q.cx = pick_coord(span); q.cy = pick_coord(span); q.cz = pick_coord(span);
    q.sx = q.cx + pick_coord(span); q.sy = q.cy + pick_coord(span);
    q.sz = q.cz + pick_coord(span);
    if ($urandom_range(19) == 0) {q.ex, q.ey, q.ez} = {q.sx, q.sy, q.sz};
    else begin
      q.ex = q.cx + pick_coord(span); q.ey = q.cy + pick_coord(span);
      q.ez = q.cz + pick_coord(span);
    end
    q.rad = ($urandom_range(9) == 0) ? RADIUS_BITS'($urandom)
                                     : RADIUS_BITS'($urandom_range(span));
    return q;
  endfunction

  function automatic query_t mk(int sx, int sy, int sz, int ex, int ey, int ez,
                                int cx, int cy, int cz, int rad);
    query_t q;
    q.sx = CB'(sx); q.sy = CB'(sy); q.sz = CB'(sz);
    q.ex = CB'(ex); q.ey = CB'(ey); q.ez = CB'(ez);
    q.cx = CB'(cx); q.cy = CB'(cy); q.cz = CB'(cz);
    q.rad = RADIUS_BITS'(rad);
    return q;
  endfunction

  initial begin
    int lo, hi;
    lo = -(1 << (CB - 1));
    hi = (1 << (CB - 1)) - 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: each path, boundary, tangent, zero length, extremes
    send(mk(0, 0, 0, 5000, 0, 0, 0, 0, 0, 100));
    send(mk(10, 0, 0, 20, 0, 0, 0, 0, 0, 100));
    send(mk(-5000, 0, 0, 5000, 0, 0, 0, 0, 0, 100));
    send(mk(-5000, 500, 0, 5000, 500, 0, 0, 0, 0, 100));
    send(mk(-5000, 100, 0, 5000, 100, 0, 0, 0, 0, 100));
    send(mk(1000, 0, 0, 5000, 0, 0, 0, 0, 0, 100));
    send(mk(3000, 0, 0, 3000, 0, 0, 0, 0, 0, 100));
    send(mk(260, 0, 0, 3000, 0, 0, 0, 0, 0, 100));
    send(mk(261, 0, 0, 3000, 0, 0, 0, 0, 0, 100));
    send(mk(lo, lo, lo, hi, hi, hi, hi, lo, hi, 0));
    send(mk(hi, hi, hi, lo, lo, lo, lo, hi, lo, (1 << RADIUS_BITS) - 1));
    send(mk(lo, lo, lo, lo, lo, lo, hi, hi, hi, 0));
    send(mk(hi, 0, lo, lo, 0, hi, 0, 0, 0, 12345));
    set_margin('0);
    send(mk(100, 0, 0, 5000, 0, 0, 0, 0, 0, 100));
    send(mk(101, 0, 0, 5000, 0, 0, 0, 0, 0, 100));
    set_margin('1);
    send(mk(lo, lo, lo, hi, hi, hi, 0, 0, 0, (1 << RADIUS_BITS) - 1));
    send(mk(70000, 0, 0, 200000, 0, 0, 0, 0, 0, 0));
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_margin(MARGIN_BITS'(160));
        1: set_margin('0);
        2: set_margin(MARGIN_BITS'($urandom));
        default: set_margin('1);
      endcase
      for (int i = 0; i < 410; i++) begin
        calm = (phase == 2 && i >= 100 && i < 250);
        if (i == 300) drain();
        send(random_query());
      end
    end
    calm = 0;
    drain();
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
